// ===== hw/rtl/sdq_pkg.sv =====
// shared types and codes for the sorted deque
package sdq_pkg;

   localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_SORT       = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } sdq_req_type;

   typedef struct packed {
      logic signed [31:0] popped;
      logic [6:0]         count;
      logic [1:0]         status;
   } sdq_rsp_type;

endpackage

// ===== hw/rtl/sorted_deque.sv =====
// sorted deque top level: circular word store in one memory plus a sort sequencer
//
// Requests: an operation word on req_word is taken at a rising edge where start
// is high and busy is low. Each request gives exactly one response word on
// rsp_word, valid for the single cycle in which rsp_strobe is high; the
// receiver cannot stall, so it must take it then.
// Push, pop, clear and unused codes: the request is held in S_EXEC and its
// response is registered from there; busy drops with it, one request at a time.
// The pop read is issued in the accepting cycle from the memory's one read port,
// and the data returns the next cycle.
// Sort: a stable insertion sort walked through the single memory port pair.
// Each word is read as the key in S_KEY; S_CMP compares it with earlier words,
// shifting larger ones up or writing the key, and S_PLACE writes it at the head.
// busy stays high for the whole walk.
// Reset (synchronous, active high) empties the queue and clears the front
// pointer; the word store itself keeps whatever it held and is never swept.
// DEPTH sets the number of stored words.
module sorted_deque #(
   parameter int DEPTH = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  sdq_pkg::sdq_req_type req_word,
   output logic                rsp_strobe,
   output sdq_pkg::sdq_rsp_type rsp_word
);
   import sdq_pkg::*;

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_KEY   = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_PLACE = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [IdxW-1:0]    front_ff, front_in;
   logic [CntW-1:0]    occ_ff, occ_in;
   logic [CntW-1:0]    i_ff, i_in;
   logic [CntW-1:0]    j_ff, j_in;
   logic signed [31:0] key_ff, key_in;
   sdq_req_type        req_ff, req_in;
   sdq_rsp_type        rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;

   logic signed [31:0] store_mem [DEPTH];
   logic signed [31:0] rdata_ff;
   logic [IdxW-1:0]    raddr;
   logic [IdxW-1:0]    waddr;
   logic signed [31:0] wdata;
   logic               we;

   logic               full;
   logic               empty;
   logic               greater;
   logic [CntW-1:0]    i_next;

   // position k in queue order mapped onto the circular store
   function automatic logic [IdxW-1:0] slot(input logic [IdxW-1:0] front,
                                            input logic [CntW-1:0] k);
      logic [IdxW:0] s;
      s = {1'b0, front} + (IdxW+1)'(k);
      if (s >= (IdxW+1)'(DEPTH)) begin
         s = s - (IdxW+1)'(DEPTH);
      end
      return s[IdxW-1:0];
   endfunction

   assign full    = (occ_ff == CntW'(DEPTH));
   assign empty   = (occ_ff == '0);
   assign greater = (rdata_ff > key_ff);
   assign i_next  = i_ff + CntW'(1);

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      occ_in        = occ_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      key_in        = key_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      raddr         = front_ff;
      waddr         = front_ff;
      wdata         = req_ff.value;
      we            = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // start the pop read right away so the data is back next cycle
            if (req_word.op == OP_POP_BACK) begin
               raddr = slot(front_ff, occ_ff - CntW'(1));
            end
            if (start) begin
               req_in   = req_word;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_in.popped = '0;
            rsp_in.status = ST_OK;
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            case (req_ff.op)
               OP_PUSH_BACK: begin
                  if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     we     = 1'b1;
                     waddr  = slot(front_ff, occ_ff);
                     occ_in = occ_ff + CntW'(1);
                  end
               end
               OP_PUSH_FRONT: begin
                  if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     front_in = (front_ff == '0) ? IdxW'(DEPTH - 1)
                                                 : front_ff - IdxW'(1);
                     we       = 1'b1;
                     waddr    = front_in;
                     occ_in   = occ_ff + CntW'(1);
                  end
               end
               OP_POP_FRONT: begin
                  if (empty) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     rsp_in.popped = rdata_ff;
                     front_in      = slot(front_ff, CntW'(1));
                     occ_in        = occ_ff - CntW'(1);
                  end
               end
               OP_POP_BACK: begin
                  if (empty) begin
                     rsp_in.status = ST_EMPTY;
                  end else begin
                     rsp_in.popped = rdata_ff;
                     occ_in        = occ_ff - CntW'(1);
                  end
               end
               OP_SORT: begin
                  if (occ_ff > CntW'(1)) begin
                     i_in          = CntW'(1);
                     raddr         = slot(front_ff, CntW'(1));
                     state_in      = S_KEY;
                     rsp_strobe_in = 1'b0;
                  end
               end
               OP_CLEAR: begin
                  occ_in   = '0;
                  front_in = '0;
               end
               default: begin
               end
            endcase
         end
         S_KEY: begin
            key_in   = rdata_ff;
            j_in     = i_ff;
            raddr    = slot(front_ff, i_ff - CntW'(1));
            state_in = S_CMP;
         end
         S_CMP: begin
            we    = 1'b1;
            waddr = slot(front_ff, j_ff);
            if (greater) begin
               // shift the larger word up one place
               wdata = rdata_ff;
               j_in  = j_ff - CntW'(1);
               if (j_ff == CntW'(1)) begin
                  state_in = S_PLACE;
               end else begin
                  raddr = slot(front_ff, j_ff - CntW'(2));
               end
            end else begin
               wdata = key_ff;
               i_in  = i_next;
               if (i_next < occ_ff) begin
                  raddr    = slot(front_ff, i_next);
                  state_in = S_KEY;
               end else begin
                  state_in      = S_IDLE;
                  rsp_strobe_in = 1'b1;
               end
            end
         end
         S_PLACE: begin
            // key goes to the head of the queue
            we    = 1'b1;
            waddr = front_ff;
            wdata = key_ff;
            i_in  = i_next;
            if (i_next < occ_ff) begin
               raddr    = slot(front_ff, i_next);
               state_in = S_KEY;
            end else begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.count = 7'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         front_ff      <= '0;
         occ_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         front_ff      <= front_in;
         occ_ff        <= occ_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      key_ff <= key_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_mem[waddr] <= wdata;
      end
      rdata_ff <= store_mem[raddr];
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== hw/rtl/sdq_checker.sv =====
// port-level checks for the sorted deque, bound to the top level
module sdq_checker #(
   parameter int DEPTH = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input sdq_pkg::sdq_req_type req_word,
   input logic                 rsp_strobe,
   input sdq_pkg::sdq_rsp_type rsp_word
);
   import sdq_pkg::*;

   // reset leaves the block idle with no response pending
   assert property (@(posedge clock) reset |=> (!busy && !rsp_strobe))
      else $error("block not idle after reset");

   // an accepted word keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // a response only shows once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while still busy");

   // a refused push only happens on a full queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == ST_FULL) |-> (rsp_word.count == 7'(DEPTH)))
      else $error("push refused while not full");

   // a failed pop reports an empty queue and no word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == ST_EMPTY)
         |-> (rsp_word.count == '0 && rsp_word.popped == '0))
      else $error("empty pop with data or count");

endmodule

bind sorted_deque sdq_checker #(.DEPTH(DEPTH)) u_sdq_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_word   (req_word),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

// ===== verif/sorted_deque_tb.sv =====
// self-checking testbench for the sorted deque: directed corners, fill and drain, random traffic
`timescale 1ns / 1ps

module sorted_deque_tb;
   import sdq_pkg::*;

   localparam int DEPTH       = 64;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int STALL_LIMIT = 12000;
   localparam int MAX_PRINTED = 40;
   localparam int EXP_DEPTH   = 16;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   sdq_req_type req_word;
   logic        rsp_strobe;
   sdq_rsp_type rsp_word;

   sorted_deque #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // shadow copy of the deque
   logic signed [31:0] dq_mem [DEPTH];
   logic [PTR_W-1:0]   dq_head;
   logic [6:0]         dq_fill;

   // expected results in order, written at acceptance and read per strobe
   sdq_rsp_type exp_ring [EXP_DEPTH];
   int          exp_wr;
   int          exp_rd;
   sdq_rsp_type want;

   int  n_errors;
   int  n_sent;
   int  n_results;
   int  n_sorts;
   int  n_full;
   int  n_empty;
   int  stall_cycles;
   int  est_fill;  // stimulus-side guess of occupancy, steers the op mix
   bit  idle_on;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic logic [PTR_W-1:0] dq_slot(input int k);
      return PTR_W'((int'(dq_head) + k) % DEPTH);
   endfunction

   function automatic sdq_rsp_type predict_rsp(input sdq_req_type r);
      sdq_rsp_type        o;
      logic signed [31:0] key;
      int                 i;
      int                 j;
      o = '0;
      o.status = ST_OK;
      case (r.op)
         OP_PUSH_BACK: begin
            if (dq_fill >= DEPTH) o.status = ST_FULL;
            else begin
               dq_mem[dq_slot(int'(dq_fill))] = r.value;
               dq_fill++;
            end
         end
         OP_PUSH_FRONT: begin
            if (dq_fill >= DEPTH) o.status = ST_FULL;
            else begin
               dq_head = PTR_W'((int'(dq_head) + DEPTH - 1) % DEPTH);
               dq_mem[dq_head] = r.value;
               dq_fill++;
            end
         end
         OP_POP_FRONT: begin
            if (dq_fill == 0) o.status = ST_EMPTY;
            else begin
               o.popped = dq_mem[dq_head];
               dq_head  = PTR_W'((int'(dq_head) + 1) % DEPTH);
               dq_fill--;
            end
         end
         OP_POP_BACK: begin
            if (dq_fill == 0) o.status = ST_EMPTY;
            else begin
               o.popped = dq_mem[dq_slot(int'(dq_fill) - 1)];
               dq_fill--;
            end
         end
         OP_SORT: begin
            // stable insertion sort in queue order, signed compare
            for (i = 1; i < int'(dq_fill); i++) begin
               key = dq_mem[dq_slot(i)];
               j = i;
               while (j > 0 && dq_mem[dq_slot(j - 1)] > key) begin
                  dq_mem[dq_slot(j)] = dq_mem[dq_slot(j - 1)];
                  j--;
               end
               dq_mem[dq_slot(j)] = key;
            end
         end
         OP_CLEAR: begin
            dq_fill = '0;
            dq_head = '0;
         end
         default: ;  // unused codes leave everything alone
      endcase
      o.count = dq_fill;
      return o;
   endfunction

   task automatic report_mismatch(input string msg);
      n_errors++;
      if (n_errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // result checker and predictor hookup
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            n_results++;
            if (exp_wr == exp_rd) begin
               report_mismatch($sformatf("result word %h with nothing expected", rsp_word));
            end else begin
               want = exp_ring[exp_rd[3:0]];
               exp_rd++;
               if (rsp_word.popped !== want.popped)
                  report_mismatch($sformatf("result %0d popped %h, want %h",
                                            n_results, rsp_word.popped, want.popped));
               if (rsp_word.count !== want.count)
                  report_mismatch($sformatf("result %0d count %0d, want %0d",
                                            n_results, rsp_word.count, want.count));
               if (rsp_word.status !== want.status)
                  report_mismatch($sformatf("result %0d status %0d, want %0d",
                                            n_results, rsp_word.status, want.status));
            end
         end
         if (start && !busy) begin
            want = predict_rsp(req_word);
            if (req_word.op == OP_SORT) n_sorts++;
            if (want.status == ST_FULL) n_full++;
            if (want.status == ST_EMPTY) n_empty++;
            exp_ring[exp_wr[3:0]] = want;
            exp_wr++;
         end
      end
   end

   // watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing accepted for %0d cycles", stall_cycles);
            $display("sorted_deque test failed");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [2:0] op, input logic [31:0] val);
      start    <= 1'b1;
      req_word <= '{op: op, value: signed'(val)};
      do @(posedge clock); while (busy);
      n_sent++;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: if (est_fill < DEPTH) est_fill++;
         OP_POP_FRONT, OP_POP_BACK:   if (est_fill > 0) est_fill--;
         OP_CLEAR:                    est_fill = 0;
         default: ;
      endcase
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results(input int settle);
      start <= 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 7))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2, 3:    return 32'($signed($urandom_range(0, 8)) - 4);  // small, with repeats
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [2:0] pick_op(input bit grow);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return 3'($urandom_range(6, 7));
      if (r < 3) return OP_CLEAR;
      if (r < 7) return OP_SORT;
      if ((r < 77) == grow) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
   endfunction

   task automatic test_directed();
      send_word(OP_POP_FRONT, 32'hffff_ffff);   // pop on empty
      send_word(OP_POP_BACK, 32'h0000_0000);
      send_word(OP_SORT, 32'h0);                // sort with nothing stored
      send_word(3'd6, 32'hffff_ffff);           // unused codes
      send_word(3'd7, 32'h0000_0000);
      send_word(OP_PUSH_BACK, 32'h7fff_ffff);
      send_word(OP_SORT, 32'h0);                // sort of a single word
      send_word(OP_PUSH_FRONT, 32'h8000_0000);
      send_word(OP_PUSH_BACK, 32'hffff_ffff);
      send_word(OP_PUSH_FRONT, 32'h0000_0000);
      send_word(OP_PUSH_BACK, 32'h7fff_ffff);
      send_word(OP_SORT, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_POP_FRONT, 32'h0);           // last word leaves
      send_word(OP_POP_FRONT, 32'h0);
      send_word(OP_PUSH_FRONT, 32'h5555_5555);  // push onto the front of an empty queue
      send_word(OP_POP_BACK, 32'h0);
      send_word(OP_PUSH_BACK, 32'haaaa_aaaa);
      send_word(OP_PUSH_FRONT, 32'h1);
      send_word(OP_CLEAR, 32'h0);
      send_word(OP_POP_BACK, 32'h0);
      wait_for_results(4);
   endtask

   task automatic test_fill_and_drain(input int rounds);
      int k;
      for (k = 0; k < rounds; k++) begin
         while (est_fill < DEPTH)
            send_word($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_word());
         send_word(OP_PUSH_BACK, rand_word());   // refused when full
         send_word(OP_PUSH_FRONT, rand_word());
         send_word(OP_SORT, $urandom);
         if (k == 0) wait_for_results(4);       // sender holds off until all is back
         while (est_fill > 0)
            send_word($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
         send_word(OP_POP_BACK, $urandom);
         send_word(OP_POP_FRONT, $urandom);
      end
      wait_for_results(4);
   endtask

   task automatic test_mixed_traffic(input int n_items);
      int k;
      bit grow;
      grow = 1'b1;
      for (k = 0; k < n_items; k++) begin
         if (grow && est_fill >= DEPTH && $urandom_range(0, 2) == 0) grow = 1'b0;
         else if (!grow && est_fill == 0 && $urandom_range(0, 2) == 0) grow = 1'b1;
         else if ($urandom_range(0, 79) == 0) grow = !grow;
         send_word(pick_op(grow), rand_word());
         if (k % 250 == 249) wait_for_results(4);
      end
      wait_for_results(4);
   endtask

   task automatic test_back_to_back(input int n_items);
      int k;
      idle_on = 1'b0;
      for (k = 0; k < n_items; k++)
         send_word(pick_op(est_fill < DEPTH / 2), rand_word());
      wait_for_results(4);
   endtask

   initial begin
      reset    = 1'b1;
      start    = 1'b0;
      req_word = '0;
      dq_mem   = '{default: '0};
      dq_head  = '0;
      dq_fill  = '0;
      exp_wr   = 0;
      exp_rd   = 0;
      n_errors = 0;
      n_sent   = 0;
      n_results = 0;
      n_sorts  = 0;
      n_full   = 0;
      n_empty  = 0;
      stall_cycles = 0;
      est_fill = 0;
      idle_on  = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_and_drain(3);
      test_mixed_traffic(1300);
      test_back_to_back(150);

      while (exp_wr != exp_rd) @(negedge clock);
      repeat (10) @(posedge clock);
      if (exp_wr != exp_rd)
         report_mismatch($sformatf("%0d results never arrived", exp_wr - exp_rd));

      $display("run covered %0d words sent and %0d results, %0d sorts",
               n_sent, n_results, n_sorts);
      $display("push on full %0d times, pop on empty %0d times, %0d mismatches",
               n_full, n_empty, n_errors);
      if (n_errors == 0) begin
         $display("sorted_deque test passed");
      end else begin
         $display("sorted_deque test failed");
      end
      $finish;
   end

endmodule
